[rtl/tls_key_share_list_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// tls_key_share_list_parser_top_macros.svh
// Assertion shorthands shared by the key share parser files.
// ----------------------------------------------------------------------------
`ifndef TLS_KEY_SHARE_LIST_PARSER_TOP_MACROS_SVH
`define TLS_KEY_SHARE_LIST_PARSER_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TKSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define TKSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/tksp_pkg.sv]
// ----------------------------------------------------------------------------
// tksp_pkg
// Shared types and codes of the key share list parser.
// ----------------------------------------------------------------------------
package tksp_pkg;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_GRP_HI = 3'd2,
    PH_GRP_LO = 3'd3,
    PH_KL_HI  = 3'd4,
    PH_KL_LO  = 3'd5,
    PH_KEY    = 3'd6
  } phase_t;

  // byte roles
  localparam logic [2:0] ROLE_LIST_LEN = 3'd0;
  localparam logic [2:0] ROLE_GRP_HI   = 3'd1;
  localparam logic [2:0] ROLE_GRP_LO   = 3'd2;
  localparam logic [2:0] ROLE_KL_HI    = 3'd3;
  localparam logic [2:0] ROLE_KL_LO    = 3'd4;
  localparam logic [2:0] ROLE_KEY      = 3'd5;
  localparam logic [2:0] ROLE_IGNORED  = 3'd6;

  // error codes
  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_LIST_TRUNC  = 3'd1;
  localparam logic [2:0] ERR_LEN_MISMATCH = 3'd2;
  localparam logic [2:0] ERR_ENTRY_TRUNC = 3'd3;
  localparam logic [2:0] ERR_BAD_KEYLEN  = 3'd4;
  localparam logic [2:0] ERR_DUP_GROUP   = 3'd5;
  localparam logic [2:0] ERR_TOO_MANY    = 3'd6;

  localparam logic [15:0] HDR_BYTES    = 16'd4;
  localparam logic [16:0] LEN_BYTES    = 17'd2;
  localparam logic [16:0] CONSUMED_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  key_byte;
    logic [15:0] group_id;
    logic [3:0]  entry_index;
    logic        key_end;
    logic        list_done;
    logic [2:0]  error_code;
  } result_t;

endpackage

[rtl/tksp_group_store.sv]
// ----------------------------------------------------------------------------
// tksp_group_store
// Groups of accepted entries, compared in parallel against a new group.
// ----------------------------------------------------------------------------
module tksp_group_store
  import tksp_pkg::*;
#(
  parameter int MAX_SHARES = 16,
  parameter int CNT_W      = 5,
  parameter int ADDR_W     = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  input  logic [CNT_W-1:0]  count,     // entries written so far
  input  logic [15:0]       grp,
  output logic              dup
);

  logic [15:0]           seen_r [MAX_SHARES];
  logic [MAX_SHARES-1:0] hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seen_r[wr_addr] <= wr_data;
    end
  end

  // only entries below the count were written
  for (genvar i = 0; i < MAX_SHARES; i++) begin : g_cmp
    assign hit[i] = (count > CNT_W'(i)) && (seen_r[i] == grp);
  end

  assign dup = |hit;

endmodule

[rtl/tksp_parser.sv]
// ----------------------------------------------------------------------------
// tksp_parser
// Parse state and per-byte decode: roles, length checks and the verdict.
// ----------------------------------------------------------------------------
`include "tls_key_share_list_parser_top_macros.svh"

module tksp_parser
  import tksp_pkg::*;
#(
  parameter int MAX_SHARES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,       // byte consumed this cycle
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    res
);

  localparam int CNT_W  = $clog2(MAX_SHARES + 1);
  localparam int ADDR_W = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;

  phase_t            phase_r, phase_nxt;
  logic [15:0]       decl_r, decl_nxt;
  logic [16:0]       consumed_r, consumed_nxt;
  logic [15:0]       kleft_r, kleft_nxt;
  logic [15:0]       group_r, group_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [2:0]        err_r, err_nxt;

  logic [16:0] inlist, diff;
  logic [15:0] rem, avail, kl, kleft_dec;
  logic        hdr_short, kl_bad, dup, full, key_done, wr_en;
  logic [CNT_W+3:0] count_ext;

  // declared list bytes still to come, counting the current one
  assign inlist    = (consumed_r >= LEN_BYTES) ? (consumed_r - LEN_BYTES) : '0;
  assign diff      = {1'b0, decl_r} - inlist;
  assign rem       = ({1'b0, decl_r} > inlist) ? diff[15:0] : '0;
  assign avail     = (rem > 16'd1) ? (rem - 16'd1) : '0;
  assign kl        = {kleft_r[15:8], data_byte};
  assign kleft_dec = (kleft_r != '0) ? (kleft_r - 16'd1) : '0;

  assign hdr_short = rem < HDR_BYTES;
  assign kl_bad    = (kl == '0) || (kl > avail);
  assign full      = count_r >= CNT_W'(MAX_SHARES);
  assign key_done  = (kleft_dec == '0);
  assign count_ext = {4'd0, count_r};

  assign wr_en = fire && (err_r == ERR_OK) && (phase_r == PH_KL_LO) &&
                 !kl_bad && !dup && !full;

  tksp_group_store #(
    .MAX_SHARES (MAX_SHARES),
    .CNT_W      (CNT_W),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (group_r),
    .count   (count_r),
    .grp     (group_r),
    .dup     (dup)
  );

  // next state
  always_comb begin
    phase_nxt = phase_r;
    decl_nxt  = decl_r;
    kleft_nxt = kleft_r;
    group_nxt = group_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (err_r == ERR_OK) begin
      case (phase_r)
        PH_LEN_HI: begin
          decl_nxt  = {data_byte, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          decl_nxt  = {decl_r[15:8], data_byte};
          phase_nxt = PH_GRP_HI;
        end
        PH_GRP_HI: begin
          if (hdr_short) begin
            err_nxt = ERR_ENTRY_TRUNC;
          end else begin
            group_nxt = {data_byte, 8'd0};
            phase_nxt = PH_GRP_LO;
          end
        end
        PH_GRP_LO: begin
          group_nxt = {group_r[15:8], data_byte};
          phase_nxt = PH_KL_HI;
        end
        PH_KL_HI: begin
          kleft_nxt = {data_byte, 8'd0};
          phase_nxt = PH_KL_LO;
        end
        PH_KL_LO: begin
          kleft_nxt = kl;
          if (kl_bad) begin
            err_nxt = ERR_BAD_KEYLEN;
          end else if (dup) begin
            err_nxt = ERR_DUP_GROUP;
          end else if (full) begin
            err_nxt = ERR_TOO_MANY;
          end else begin
            phase_nxt = PH_KEY;
          end
        end
        PH_KEY: begin
          kleft_nxt = kleft_dec;
          if (key_done) begin
            phase_nxt = PH_GRP_HI;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    consumed_nxt = (consumed_r < CONSUMED_MAX) ? (consumed_r + 17'd1) : consumed_r;
  end

  // outputs
  always_comb begin
    res             = '0;
    res.byte_role   = ROLE_IGNORED;
    res.list_done   = last_byte;
    if (err_r == ERR_OK) begin
      case (phase_r)
        PH_LEN_HI, PH_LEN_LO: res.byte_role = ROLE_LIST_LEN;
        PH_GRP_HI:            res.byte_role = ROLE_GRP_HI;
        PH_GRP_LO:            res.byte_role = ROLE_GRP_LO;
        PH_KL_HI:             res.byte_role = ROLE_KL_HI;
        PH_KL_LO:             res.byte_role = ROLE_KL_LO;
        PH_KEY: begin
          res.byte_role = ROLE_KEY;
          res.key_byte  = data_byte;
          res.key_end   = key_done;
        end
        default:              res.byte_role = ROLE_IGNORED;
      endcase
      if (res.byte_role != ROLE_LIST_LEN && res.byte_role != ROLE_IGNORED) begin
        res.group_id    = group_nxt;
        res.entry_index = count_ext[3:0];
      end
    end
    res.error_code = err_nxt;
    if (last_byte) begin
      if (consumed_nxt < LEN_BYTES) begin
        res.error_code = ERR_LIST_TRUNC;
      end else if ((consumed_nxt - LEN_BYTES) != {1'b0, decl_nxt}) begin
        res.error_code = ERR_LEN_MISMATCH;
      end
    end
  end

  // the last byte of a body returns the parser to its reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      phase_r    <= PH_LEN_HI;
      decl_r     <= '0;
      consumed_r <= '0;
      kleft_r    <= '0;
      group_r    <= '0;
      count_r    <= '0;
      err_r      <= ERR_OK;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      decl_r     <= decl_nxt;
      consumed_r <= consumed_nxt;
      kleft_r    <= kleft_nxt;
      group_r    <= group_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
    end
  end

  `TKSP_ASSERT_IMP(a_key_left, phase_r == PH_KEY, kleft_r != '0, "key phase with no bytes left")
  `TKSP_ASSERT(a_count_max, count_r <= CNT_W'(MAX_SHARES), "entry count past MAX_SHARES")
  `TKSP_ASSERT_IMP(a_err_holds, fire && !last_byte && err_r != ERR_OK, err_nxt == err_r, "latched error changed")

endmodule

[rtl/tls_key_share_list_parser_top.sv]
// ----------------------------------------------------------------------------
// tls_key_share_list_parser_top
// Streaming parser for the key share extension body of a TLS 1.3 hello.
// ----------------------------------------------------------------------------
// Usage:
//   The body enters one byte per beat on the in_ channel, in_tlast on its
//   final byte. Every input beat yields exactly one output beat: the byte's
//   role on out_tuser, and key byte, group, entry index, key end marker and
//   error code on out_tdata. out_tlast repeats the input's last marker, and
//   the error code on that beat is the verdict for the whole list.
//   Throughput is one byte per cycle unless out_tready stalls it: the
//   duplicate-group check compares the current group against all stored
//   groups at once. Beats pass the input register, then the result register.
//   When out_tready is low the result register holds its beat and the input
//   register keeps one more byte; in_tready drops only when both are full.
//   After reset, and after every beat marked last, the parser waits for a new
//   list length. The group store has no reset; only entries already written
//   in the current list are ever compared.
// ----------------------------------------------------------------------------
`include "tls_key_share_list_parser_top_macros.svh"

module tls_key_share_list_parser_top
  import tksp_pkg::*;
#(
  parameter int MAX_SHARES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] key_byte, [23:8] group_id,
                                  // [27:24] entry_index, [28] key_end,
                                  // [31:29] error_code
  output logic [2:0]  out_tuser,  // [2:0] byte_role
  output logic        out_tlast   // list_done
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  result_t    res;
  logic       advance;

  // move the held byte into the result register when that slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  tksp_parser #(
    .MAX_SHARES (MAX_SHARES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.byte_role;
  assign out_tlast  = out_res_r.list_done;
  assign out_tdata  = {out_res_r.error_code, out_res_r.key_end, out_res_r.entry_index,
                       out_res_r.group_id, out_res_r.key_byte};

  `TKSP_ASSERT_IMP(a_ignored_err, out_tvalid && out_tuser == ROLE_IGNORED, out_tdata[31:29] != ERR_OK, "ignored byte without error")
  `TKSP_ASSERT_IMP(a_nonkey_clean, out_tvalid && out_tuser != ROLE_KEY, out_tdata[7:0] == 8'd0 && !out_tdata[28], "key fields set on non-key byte")
  `TKSP_ASSERT_IMP(a_len_no_group, out_tvalid && out_tuser == ROLE_LIST_LEN, out_tdata[27:8] == 20'd0, "group fields set on length byte")

endmodule

[tb/sv/key_share_parse_checker.sv]
// ----------------------------------------------------------------------------
// share_list_checker
// Watches both streams of the key share list parser, predicts every result
// beat from the accepted input bytes and compares it field by field.
// ----------------------------------------------------------------------------
module share_list_checker
  import tksp_pkg::*;
#(
  parameter int MAX_SHARES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [7:0] key_byte, [23:8] group_id,
                                  // [27:24] entry_index, [28] key_end,
                                  // [31:29] error_code
  input  logic [2:0]  out_tuser,  // [2:0] byte_role
  input  logic        out_tlast,  // list_done
  output int unsigned mismatch_count,
  output int unsigned pending_beats
);

  // parser state as seen from outside
  phase_t      phase;
  logic [15:0] declared_len;
  logic [16:0] consumed;
  logic [15:0] keys_left;
  logic [15:0] cur_group;
  int unsigned n_entries;
  logic [15:0] group_store [MAX_SHARES];
  logic [2:0]  err_latch;

  result_t     predicted_beats [$];
  result_t     want;
  int unsigned mismatch_total = 0;

  function automatic void clear_parser();
    phase        = PH_LEN_HI;
    declared_len = '0;
    consumed     = '0;
    keys_left    = '0;
    cur_group    = '0;
    n_entries    = 0;
    err_latch    = ERR_OK;
  endfunction

  function automatic result_t parse_next_byte(input logic [7:0] d, input logic is_last);
    result_t     r;
    logic [16:0] in_list;
    logic [16:0] rem;
    logic [16:0] avail;
    logic [15:0] kl;
    logic        dup;
    int          i;
    r           = '0;
    r.byte_role = ROLE_IGNORED;
    in_list = (consumed >= LEN_BYTES) ? consumed - LEN_BYTES : '0;
    rem     = ({1'b0, declared_len} > in_list) ? {1'b0, declared_len} - in_list : '0;
    if (err_latch == ERR_OK) begin
      case (phase)
        PH_LEN_HI: begin
          r.byte_role  = ROLE_LIST_LEN;
          declared_len = {d, 8'h00};
          phase        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          r.byte_role  = ROLE_LIST_LEN;
          declared_len = {declared_len[15:8], d};
          phase        = PH_GRP_HI;
        end
        PH_GRP_HI: begin
          r.byte_role = ROLE_GRP_HI;
          // header would run past the declared list
          if (rem < {1'b0, HDR_BYTES}) begin
            err_latch = ERR_ENTRY_TRUNC;
          end else begin
            cur_group = {d, 8'h00};
            phase     = PH_GRP_LO;
          end
        end
        PH_GRP_LO: begin
          r.byte_role = ROLE_GRP_LO;
          cur_group   = {cur_group[15:8], d};
          phase       = PH_KL_HI;
        end
        PH_KL_HI: begin
          r.byte_role = ROLE_KL_HI;
          keys_left   = {d, 8'h00};
          phase       = PH_KL_LO;
        end
        PH_KL_LO: begin
          r.byte_role = ROLE_KL_LO;
          kl          = {keys_left[15:8], d};
          keys_left   = kl;
          avail       = (rem > 17'd1) ? rem - 17'd1 : '0;
          dup         = 1'b0;
          for (i = 0; i < MAX_SHARES; i++) begin
            if (i < n_entries && group_store[i] == cur_group) dup = 1'b1;
          end
          if (kl == 16'd0 || {1'b0, kl} > avail) begin
            err_latch = ERR_BAD_KEYLEN;
          end else if (dup) begin
            err_latch = ERR_DUP_GROUP;
          end else if (n_entries >= MAX_SHARES) begin
            err_latch = ERR_TOO_MANY;
          end else begin
            group_store[n_entries] = cur_group;
            phase                  = PH_KEY;
          end
        end
        default: begin
          r.byte_role = ROLE_KEY;
          r.key_byte  = d;
          if (keys_left != 16'd0) keys_left = keys_left - 16'd1;
          if (keys_left == 16'd0) begin
            r.key_end = 1'b1;
            phase     = PH_GRP_HI;
          end
        end
      endcase
      if (r.byte_role != ROLE_LIST_LEN) begin
        r.group_id    = cur_group;
        r.entry_index = n_entries[3:0];
      end
      if (r.key_end) n_entries++;
    end
    if (consumed < CONSUMED_MAX) consumed = consumed + 17'd1;
    r.list_done  = is_last;
    r.error_code = err_latch;
    if (is_last) begin
      if (consumed < LEN_BYTES) begin
        r.error_code = ERR_LIST_TRUNC;
      end else if (consumed - LEN_BYTES != {1'b0, declared_len}) begin
        r.error_code = ERR_LEN_MISMATCH;
      end
      clear_parser();
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, exp_v, act_v);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      predicted_beats.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_beats.size() == 0) begin
          $display("%0t unexpected result beat: tuser %0h tdata %h tlast %b",
                   $time, out_tuser, out_tdata, out_tlast);
          mismatch_total++;
        end else begin
          want = predicted_beats.pop_front();
          check_field("byte_role",   16'(want.byte_role),   16'(out_tuser));
          check_field("key_byte",    16'(want.key_byte),    16'(out_tdata[7:0]));
          check_field("group_id",    want.group_id,         out_tdata[23:8]);
          check_field("entry_index", 16'(want.entry_index), 16'(out_tdata[27:24]));
          check_field("key_end",     16'(want.key_end),     16'(out_tdata[28]));
          check_field("list_done",   16'(want.list_done),   16'(out_tlast));
          check_field("error_code",  16'(want.error_code),  16'(out_tdata[31:29]));
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_beats.push_back(parse_next_byte(in_tdata, in_tlast));
      end
    end
    mismatch_count <= mismatch_total;
    pending_beats  <= predicted_beats.size();
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the key share list parser. Feeds extension bodies
// byte by byte (directed lists, then random well-formed and damaged lists and
// noise), stalls both streams at random, and leaves all prediction and
// comparison to share_list_checker.
// ----------------------------------------------------------------------------
module tb;
  import tksp_pkg::*;

  localparam int MAX_SHARES  = 16;
  localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
  localparam int STEADY_AT   = 650;    // input beats before idling stops
  localparam int RANDOM_BEATS = 800;

  // ways a random list gets damaged
  typedef enum int {
    FLAW_NONE,
    FLAW_LEN_OFF,       // declared list length off by a little, or all ones
    FLAW_KEYLEN_ZERO,   // one entry claims an empty key
    FLAW_KEYLEN_OVER,   // last entry claims more key than the list holds
    FLAW_CUT_SHORT,     // tail of the body dropped
    FLAW_EXTRA_BYTES,   // junk after the declared list
    FLAW_HEADER_TAIL    // 1..3 declared bytes left, too few for a header
  } list_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int unsigned mismatch_count;
  int unsigned pending_beats;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_flow = 1'b0;   // set for the last part: no idling anywhere
  logic [7:0]  frame_bytes [$];

  always #4 clk = ~clk;

  tls_key_share_list_parser_top #(
    .MAX_SHARES(MAX_SHARES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  share_list_checker #(
    .MAX_SHARES(MAX_SHARES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats)
  );

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side backpressure: random stall bursts between runs of ready,
  // with long runs mixed in. Always ready once steady_flow is set.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // One input beat; returns at the edge that took it. A random idle burst
  // may follow, so gaps land on every parse phase.
  task automatic drive_byte(input logic [7:0] value, input logic is_last);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (!steady_flow && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      drive_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Builds one extension body in frame_bytes. numbered gives distinct
  // groups and one-byte keys, used for the entry-count limit.
  task automatic build_list(input int n_entries, input bit from_pool, input bit numbered,
                            input list_flaw_t flaw);
    int          e;
    int          kl;
    int          bad_entry;
    logic [15:0] grp;
    logic [15:0] kl_field;
    logic [15:0] declared;
    frame_bytes.delete();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    // an oversized key length must be on the last entry to overrun the list
    if (n_entries == 0) bad_entry = -1;
    else if (flaw == FLAW_KEYLEN_OVER) bad_entry = n_entries - 1;
    else bad_entry = $urandom_range(0, n_entries - 1);
    for (e = 0; e < n_entries; e++) begin
      if (numbered) grp = 16'h0100 + e[15:0];
      else if (from_pool) grp = 16'h0017 + 16'($urandom_range(0, 7));  // dups likely
      else grp = 16'($urandom_range(0, 16'hFFFF));
      if (numbered) kl = 1;
      else if ($urandom_range(0, 29) == 0) kl = $urandom_range(256, 300);
      else if ($urandom_range(0, 9) == 0) kl = $urandom_range(1, 64);
      else kl = $urandom_range(1, 8);
      kl_field = kl[15:0];
      if (e == bad_entry && flaw == FLAW_KEYLEN_ZERO) begin
        kl_field = 16'h0000;
      end else if (e == bad_entry && flaw == FLAW_KEYLEN_OVER) begin
        kl_field = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                 : 16'(kl + $urandom_range(1, 300));
      end
      frame_bytes.push_back(grp[15:8]);
      frame_bytes.push_back(grp[7:0]);
      frame_bytes.push_back(kl_field[15:8]);
      frame_bytes.push_back(kl_field[7:0]);
      repeat (kl) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (flaw == FLAW_HEADER_TAIL) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    declared = 16'(frame_bytes.size() - 2);
    if (flaw == FLAW_LEN_OFF) begin
      if ($urandom_range(0, 4) == 0) declared = 16'hFFFF;
      else if ($urandom_range(0, 1) == 0) declared = declared + 16'($urandom_range(1, 3));
      else declared = declared - 16'($urandom_range(1, 3));
    end
    frame_bytes[0] = declared[15:8];
    frame_bytes[1] = declared[7:0];
    if (flaw == FLAW_CUT_SHORT) begin
      repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
    end
    if (flaw == FLAW_EXTRA_BYTES) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly clean or lightly damaged lists, some at the entry limit, some noise.
  task automatic random_frame();
    int         pick;
    list_flaw_t flaw;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 12) begin
      // exactly at the limit is fine, one more is too many
      build_list($urandom_range(MAX_SHARES, MAX_SHARES + 1), 1'b0, 1'b1, FLAW_NONE);
    end else begin
      flaw = FLAW_NONE;
      if ($urandom_range(0, 1) == 0) flaw = list_flaw_t'($urandom_range(1, 6));
      build_list($urandom_range(0, 4), 1'($urandom_range(0, 1)), 1'b0, flaw);
    end
    send_frame();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed lists ---
    // lone byte: list truncated
    frame_bytes = '{8'h00};
    send_frame();
    // empty list, length zero
    frame_bytes = '{8'h00, 8'h00};
    send_frame();
    // one entry, group all ones, key bytes at both extremes
    frame_bytes = '{8'h00, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF};
    send_frame();
    // same group twice: second key length byte raises duplicate group
    frame_bytes = '{8'h00, 8'h0A, 8'h00, 8'h1D, 8'h00, 8'h01, 8'hAB,
                    8'h00, 8'h1D, 8'h00, 8'h01, 8'hCD};
    send_frame();

    // --- random lists, then a stretch with no idling ---
    while (bytes_sent < STEADY_AT) random_frame();
    steady_flow = 1'b1;
    while (bytes_sent < RANDOM_BEATS) random_frame();
    in_tvalid <= 1'b0;

    // drain, then allow the pipeline to show any stray beat
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tksp_pkg.sv
rtl/tksp_group_store.sv
rtl/tksp_parser.sv
rtl/tls_key_share_list_parser_top.sv
tb/sv/key_share_parse_checker.sv
tb/sv/tb.sv
